// File: rtl/core/ita_pkg.sv
`timescale 1ns / 1ps
// shared constants and the job record for the integer to ascii formatter
package ita_pkg;

    localparam int MaxDigits  = 11;
    localparam int DigitW     = 4;
    localparam int CountW     = 6;
    localparam int NdigW      = $clog2(MaxDigits + 1);
    localparam int MaxField   = 32;
    localparam int QueueDepth = 2;

    typedef enum logic [1:0] {
        BASE_DEC     = 2'd0,
        BASE_OCT     = 2'd1,
        BASE_HEX     = 2'd2,
        BASE_HEX_ALT = 2'd3
    } base_sel_t;

    typedef struct packed {
        logic [MaxDigits-1:0][DigitW-1:0] digits;
        logic [NdigW-1:0]                 ndig;
        logic                             neg;
        logic [CountW-1:0]                spaces;
        logic [CountW-1:0]                zeros;
    } job_t;

endpackage

// File: rtl/core/ita_front.sv
`timescale 1ns / 1ps
// front end: takes an item, clamps the format and converts the magnitude to digits
module ita_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [31:0]        s_magnitude,
    input  logic               s_negative,
    input  logic [1:0]         s_base_select,
    input  logic [5:0]         s_field_width,
    input  logic [5:0]         s_precision,
    output logic               j_valid,
    input  logic               j_ready,
    output ita_pkg::job_t      j_data
);
    import ita_pkg::*;

    localparam logic [31:0] Recip10  = 32'hCCCC_CCCD;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t                            state_reg;
    logic [31:0]                       mag_reg;
    logic [63:0]                       prod_reg;
    logic [NdigW-1:0]                  ndig_reg;
    logic                              neg_reg;
    logic                              hex_reg;
    logic [CountW-1:0]                 width_reg;
    logic [CountW-1:0]                 prec_reg;
    logic [MaxDigits-1:0][DigitW-1:0]  digit_reg;

    logic [31:0]       mag_shift;
    logic [31:0]       quot;
    logic [31:0]       rem;
    logic [CountW-1:0] ndig_ext;
    logic [CountW-1:0] body;
    logic [CountW-1:0] total;

    function automatic logic [CountW-1:0] clamp(input logic [CountW-1:0] v);
        return (v > CountW'(MaxField)) ? CountW'(MaxField) : v;
    endfunction

    always_comb begin
        mag_shift = hex_reg ? (mag_reg >> 4) : (mag_reg >> 3);
        quot      = {3'b000, prod_reg[63:35]};
        rem       = mag_reg - ((quot << 3) + (quot << 1));
        ndig_ext  = CountW'(ndig_reg);
        body      = (ndig_ext > prec_reg) ? ndig_ext : prec_reg;
        total     = body + CountW'(neg_reg);
    end

    always_comb begin
        j_data.digits = digit_reg;
        j_data.ndig   = ndig_reg;
        j_data.neg    = neg_reg;
        j_data.spaces = (width_reg > total) ? width_reg - total : '0;
        j_data.zeros  = (prec_reg > ndig_ext) ? prec_reg - ndig_ext : '0;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign j_valid = (state_reg == ST_DONE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        mag_reg   <= s_magnitude;
                        neg_reg   <= s_negative;
                        hex_reg   <= (s_base_select != BASE_OCT);
                        width_reg <= clamp(s_field_width);
                        prec_reg  <= clamp(s_precision);
                        ndig_reg  <= '0;
                        state_reg <= (s_base_select == BASE_DEC) ? ST_MUL : ST_CONV;
                    end
                end
                ST_CONV: begin
                    digit_reg[ndig_reg] <= hex_reg ? mag_reg[3:0] : {1'b0, mag_reg[2:0]};
                    mag_reg  <= mag_shift;
                    ndig_reg <= ndig_reg + NdigW'(1);
                    if (mag_shift == '0) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_MUL: begin
                    prod_reg  <= mag_reg * Recip10;
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    digit_reg[ndig_reg] <= rem[DigitW-1:0];
                    mag_reg  <= quot;
                    ndig_reg <= ndig_reg + NdigW'(1);
                    state_reg <= (quot == '0) ? ST_DONE : ST_MUL;
                end
                ST_DONE: begin
                    if (j_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// File: rtl/core/ita_queue.sv
`timescale 1ns / 1ps
// short job queue between the front end and the character sequencer
module ita_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  ita_pkg::job_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output ita_pkg::job_t out_data
);
    import ita_pkg::*;

    localparam int PtrW = $clog2(QueueDepth);
    localparam int CntW = $clog2(QueueDepth + 1);

    job_t            mem_reg [QueueDepth];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [CntW-1:0] count_reg;

    logic push;
    logic pop;

    assign in_ready  = (count_reg != CntW'(QueueDepth));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                mem_reg[wr_ptr_reg] <= in_data;
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(QueueDepth - 1)) ? '0
                                                                   : wr_ptr_reg + PtrW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(QueueDepth - 1)) ? '0
                                                                   : rd_ptr_reg + PtrW'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CntW'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CntW'(1);
            end
        end
    end

endmodule

// File: rtl/core/ita_back.sv
`timescale 1ns / 1ps
// back end: walks a job through spaces, sign, zeros and digits, one character a cycle while the output is not stalled
module ita_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          j_valid,
    output logic          j_ready,
    input  ita_pkg::job_t j_data,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [7:0]    m_character,
    output logic          m_last_char
);
    import ita_pkg::*;

    localparam logic [7:0] AsciiSpace = 8'h20;
    localparam logic [7:0] AsciiMinus = 8'h2D;
    localparam logic [7:0] AsciiZero  = 8'h30;
    localparam logic [7:0] AsciiA     = 8'h41;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SPACE,
        ST_SIGN,
        ST_ZERO,
        ST_DIGIT
    } state_t;

    state_t                            state_reg;
    logic [CountW-1:0]                 spaces_reg;
    logic [CountW-1:0]                 zeros_reg;
    logic [NdigW-1:0]                  idx_reg;
    logic                              neg_reg;
    logic [MaxDigits-1:0][DigitW-1:0]  digits_reg;
    logic                              m_valid_reg;
    logic [7:0]                        m_character_reg;
    logic                              m_last_reg;

    logic             advance;
    logic             emit;
    logic [NdigW-1:0] didx;
    logic [7:0]       digit_ascii;

    function automatic logic [7:0] digit_char(input logic [DigitW-1:0] d);
        return (d < DigitW'(10)) ? AsciiZero + 8'(d) : AsciiA + 8'(d) - 8'd10;
    endfunction

    assign advance     = !m_valid_reg || m_ready;
    assign emit        = advance && (state_reg != ST_IDLE);
    assign didx        = idx_reg - NdigW'(1);
    assign digit_ascii = digit_char(digits_reg[didx]);
    assign j_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_character = m_character_reg;
    assign m_last_char = m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (j_valid) begin
                        spaces_reg <= j_data.spaces;
                        zeros_reg  <= j_data.zeros;
                        idx_reg    <= j_data.ndig;
                        neg_reg    <= j_data.neg;
                        digits_reg <= j_data.digits;
                        state_reg  <= (j_data.spaces != '0) ? ST_SPACE :
                                      j_data.neg            ? ST_SIGN  :
                                      (j_data.zeros != '0)  ? ST_ZERO  : ST_DIGIT;
                    end
                end
                ST_SPACE: begin
                    if (advance) begin
                        m_character_reg <= AsciiSpace;
                        m_last_reg      <= 1'b0;
                        spaces_reg      <= spaces_reg - CountW'(1);
                        if (spaces_reg == CountW'(1)) begin
                            state_reg <= neg_reg              ? ST_SIGN :
                                         (zeros_reg != '0)    ? ST_ZERO : ST_DIGIT;
                        end
                    end
                end
                ST_SIGN: begin
                    if (advance) begin
                        m_character_reg <= AsciiMinus;
                        m_last_reg      <= 1'b0;
                        state_reg       <= (zeros_reg != '0) ? ST_ZERO : ST_DIGIT;
                    end
                end
                ST_ZERO: begin
                    if (advance) begin
                        m_character_reg <= AsciiZero;
                        m_last_reg      <= 1'b0;
                        zeros_reg       <= zeros_reg - CountW'(1);
                        if (zeros_reg == CountW'(1)) begin
                            state_reg <= ST_DIGIT;
                        end
                    end
                end
                ST_DIGIT: begin
                    if (advance) begin
                        m_character_reg <= digit_ascii;
                        m_last_reg      <= (idx_reg == NdigW'(1));
                        idx_reg         <= didx;
                        if (idx_reg == NdigW'(1)) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// File: rtl/core/integer_to_ascii_padded.sv
`timescale 1ns / 1ps
// top level of the printf-style integer formatter
// Each item turns into one ASCII character per output item: leading spaces, an optional
// minus sign, zeros up to the precision, then the digits most significant first, with
// m_last_char set on the final digit. Width and precision saturate at 32. The front end
// converts while the back end emits the previous item, with a two-item queue between
// them. Octal and hex convert one digit per step; decimal takes a reciprocal multiply
// and then a remainder step for each digit. The back end emits one character per cycle
// while m_ready does not stall it, spaces + sign + max(digits, precision) characters per
// item, and takes a new job only when idle, so the sustained rate is set by whichever of
// the two is slower for the item mix.
module integer_to_ascii_padded (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_magnitude,
    input  logic        s_negative,
    input  logic [1:0]  s_base_select,
    input  logic [5:0]  s_field_width,
    input  logic [5:0]  s_precision,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_character,
    output logic        m_last_char
);
    import ita_pkg::*;

    logic fq_valid;
    logic fq_ready;
    job_t fq_data;
    logic qb_valid;
    logic qb_ready;
    job_t qb_data;

    ita_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_magnitude   (s_magnitude),
        .s_negative    (s_negative),
        .s_base_select (s_base_select),
        .s_field_width (s_field_width),
        .s_precision   (s_precision),
        .j_valid       (fq_valid),
        .j_ready       (fq_ready),
        .j_data        (fq_data)
    );

    ita_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_data),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_data  (qb_data)
    );

    ita_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .j_valid     (qb_valid),
        .j_ready     (qb_ready),
        .j_data      (qb_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_character (m_character),
        .m_last_char (m_last_char)
    );

endmodule

// File: rtl/core/ita_checker.sv
`timescale 1ns / 1ps
// port-level checks on the integer formatter, bound to the top level
module ita_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_character,
    input logic       m_last_char
);

    logic is_digit;
    logic is_pad;

    assign is_digit = (m_character >= 8'h30 && m_character <= 8'h39) ||
                      (m_character >= 8'h41 && m_character <= 8'h46);
    assign is_pad   = (m_character == 8'h20) || (m_character == 8'h2D);

    // a stalled item holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_character) && $stable(m_last_char))
        else $error("output item changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

    a_char_set: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> is_digit || is_pad)
        else $error("unexpected output character");

    // the final character is always a digit
    a_last_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last_char |-> is_digit)
        else $error("last flag on a non-digit");

    // a sign or space never directly follows a digit within one number
    a_no_pad_after_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && is_digit && !m_last_char ##1 m_valid |-> is_digit)
        else $error("padding after a digit");

endmodule

bind integer_to_ascii_padded ita_checker u_ita_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_character (m_character),
    .m_last_char (m_last_char)
);

// File: sim/tb_integer_to_ascii_padded.sv
`timescale 1ns / 1ps
// testbench for the integer to ascii formatter: directed and random numbers against a predictor
module tb_integer_to_ascii_padded;

    import ita_pkg::*;

    typedef struct {
        logic [31:0] mag;
        logic        neg;
        base_sel_t   sel;
        logic [5:0]  fw;
        logic [5:0]  prec;
    } number_t;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } char_t;

    localparam logic [127:0] DigitSet = "0123456789ABCDEF";
    localparam logic [7:0]   ChSpace  = " ";
    localparam logic [7:0]   ChMinus  = "-";
    localparam logic [7:0]   ChZero   = "0";
    localparam int           TailCycles = 40;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [31:0] s_magnitude;
    logic        s_negative;
    logic [1:0]  s_base_select;
    logic [5:0]  s_field_width;
    logic [5:0]  s_precision;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_character;
    logic        m_last_char;

    char_t pending_chars[$];
    int    error_count  = 0;
    bit    source_steady = 0;
    bit    sink_steady   = 0;

    integer_to_ascii_padded u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_magnitude   (s_magnitude),
        .s_negative    (s_negative),
        .s_base_select (s_base_select),
        .s_field_width (s_field_width),
        .s_precision   (s_precision),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_character   (m_character),
        .m_last_char   (m_last_char)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #30_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic int gap_cycles();
        int r;
        r = $urandom_range(0, 15);
        if (r < 8) begin
            return 0;
        end
        if (r < 14) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // expected characters of one number, appended to the pending queue
    function automatic void format_number(number_t n);
        int          base;
        int          nd;
        int          w;
        int          p;
        int          body;
        int          total;
        int          spaces;
        int          i;
        logic [31:0] v;
        logic [3:0]  dig [MaxDigits];
        char_t       c;
        base = (n.sel == BASE_DEC) ? 10 : (n.sel == BASE_OCT) ? 8 : 16;
        w = (n.fw > MaxField) ? MaxField : n.fw;
        p = (n.prec > MaxField) ? MaxField : n.prec;
        v = n.mag;
        nd = 0;
        do begin
            dig[nd] = 4'(v % base);
            nd++;
            v = v / base;
        end while (v != 0 && nd < MaxDigits);
        body = (nd > p) ? nd : p;
        total = n.neg + body;
        spaces = (w > total) ? w - total : 0;
        c.last = 1'b0;
        c.ch = ChSpace;
        for (i = 0; i < spaces; i++) begin
            pending_chars.push_back(c);
        end
        if (n.neg) begin
            c.ch = ChMinus;
            pending_chars.push_back(c);
        end
        c.ch = ChZero;
        for (i = nd; i < p; i++) begin
            pending_chars.push_back(c);
        end
        for (i = nd - 1; i >= 0; i--) begin
            c.ch = DigitSet[8*(15-dig[i]) +: 8];
            c.last = (i == 0);
            pending_chars.push_back(c);
        end
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_character();
        char_t e;
        if (pending_chars.size() == 0) begin
            report_mismatch($sformatf("unexpected character %h last %b",
                                      m_character, m_last_char));
            return;
        end
        e = pending_chars.pop_front();
        if (m_character !== e.ch) begin
            report_mismatch($sformatf("character %h, expected %h", m_character, e.ch));
        end
        if (m_last_char !== e.last) begin
            report_mismatch($sformatf("last_char %b, expected %b on %h",
                                      m_last_char, e.last, e.ch));
        end
    endtask

    // result side: check each accepted item, then pick the next ready
    initial begin
        int stall_left;
        stall_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                check_character();
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if (!sink_steady && $urandom_range(0, 3) == 0) begin
                    stall_left = gap_cycles();
                end
            end
        end
    end

    task automatic send_number(input number_t n);
        int gap;
        gap = source_steady ? 0 : gap_cycles();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_magnitude   <= n.mag;
        s_negative    <= n.neg;
        s_base_select <= n.sel;
        s_field_width <= n.fw;
        s_precision   <= n.prec;
        do @(posedge aclk); while (!(s_valid && s_ready));
        format_number(n);
    endtask

    task automatic send_fields(input logic [31:0] mag, input logic neg, input base_sel_t sel,
                               input logic [5:0] fw, input logic [5:0] prec);
        number_t n;
        n.mag  = mag;
        n.neg  = neg;
        n.sel  = sel;
        n.fw   = fw;
        n.prec = prec;
        send_number(n);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge aclk);
    endtask

    task automatic test_zero_values();
        send_fields(32'd0, 1'b0, BASE_DEC, 6'd0, 6'd0);
        send_fields(32'd0, 1'b0, BASE_OCT, 6'd6, 6'd3);
        send_fields(32'd0, 1'b1, BASE_HEX, 6'd0, 6'd0);
    endtask

    task automatic test_bases();
        send_fields(32'hFFFF_FFFF, 1'b0, BASE_DEC, 6'd0, 6'd0);
        send_fields(32'hFFFF_FFFF, 1'b0, BASE_OCT, 6'd0, 6'd0);
        send_fields(32'hFFFF_FFFF, 1'b0, BASE_HEX, 6'd0, 6'd0);
        send_fields(32'hFFFF_FFFF, 1'b1, BASE_HEX_ALT, 6'd12, 6'd0);
        send_fields(32'h89AB_CDEF, 1'b0, BASE_HEX, 6'd0, 6'd0);
        send_fields(32'h8000_0000, 1'b0, BASE_OCT, 6'd0, 6'd0);
        send_fields(32'h0000_FEDC, 1'b1, BASE_HEX_ALT, 6'd3, 6'd6);
    endtask

    task automatic test_padding();
        send_fields(32'd255, 1'b1, BASE_DEC, 6'd8, 6'd5);
        send_fields(32'd12345, 1'b0, BASE_DEC, 6'd5, 6'd0);
        send_fields(32'd12345, 1'b1, BASE_DEC, 6'd3, 6'd2);
        send_fields(32'd7, 1'b0, BASE_OCT, 6'd10, 6'd0);
        send_fields(32'd1_000_000_000, 1'b0, BASE_DEC, 6'd0, 6'd12);
    endtask

    // width and precision above the limit saturate
    task automatic test_saturation();
        send_fields(32'hFFFF_FFFF, 1'b0, BASE_DEC, 6'd63, 6'd0);
        send_fields(32'd5, 1'b1, BASE_HEX, 6'd33, 6'd63);
        send_fields(32'd1, 1'b0, BASE_OCT, 6'd40, 6'd40);
        send_fields(32'h10, 1'b0, BASE_HEX, 6'd32, 6'd32);
    endtask

    task automatic test_drained_restart();
        send_fields(32'd42, 1'b0, BASE_DEC, 6'd4, 6'd0);
        send_fields(32'o777, 1'b1, BASE_OCT, 6'd0, 6'd4);
        send_fields(32'hBEEF, 1'b0, BASE_HEX, 6'd9, 6'd0);
        wait_drained();
        send_fields(32'd9, 1'b0, BASE_DEC, 6'd2, 6'd2);
        send_fields(32'hC0DE, 1'b1, BASE_HEX_ALT, 6'd0, 6'd0);
    endtask

    task automatic test_random_mix(input int count);
        number_t n;
        int      i;
        for (i = 0; i < count; i++) begin
            case ($urandom_range(0, 5))
                0:       n.mag = $urandom_range(0, 9);
                1:       n.mag = $urandom_range(0, 999);
                2:       n.mag = $urandom() >> $urandom_range(0, 31);
                3:       n.mag = 32'hFFFF_FFFF >> $urandom_range(0, 31);
                default: n.mag = $urandom();
            endcase
            n.neg  = 1'($urandom_range(0, 1));
            n.sel  = base_sel_t'($urandom_range(0, 3));
            n.fw   = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63))
                                                 : 6'($urandom_range(0, 20));
            n.prec = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63))
                                                 : 6'($urandom_range(0, 12));
            send_number(n);
        end
    endtask

    initial begin
        aresetn       <= 1'b0;
        s_valid       <= 1'b0;
        s_magnitude   <= '0;
        s_negative    <= 1'b0;
        s_base_select <= '0;
        s_field_width <= '0;
        s_precision   <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        test_zero_values();
        test_bases();
        test_padding();
        test_saturation();
        test_drained_restart();

        test_random_mix(84);
        source_steady = 1;
        sink_steady   = 1;
        test_random_mix(84);
        sink_steady   = 0;
        test_random_mix(84);
        source_steady = 0;
        test_random_mix(84);

        wait_drained();
        repeat (TailCycles) @(posedge aclk);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
